FILE: src/rc6fe_pkg.sv
// ----------------------------------------------------------------------------
// rc6fe_pkg
// Shared types, register codes and the control program of the RC6 encoder.
// ----------------------------------------------------------------------------
package rc6fe_pkg;

	localparam int STEP_W = 4;
	localparam int POS_W  = 5;
	localparam int CODE_W = 27;
	localparam int DUR_W  = 16;
	localparam int HALF_W = 14;
	localparam int IDX_W  = 3;

	localparam logic [STEP_W-1:0] STEP_LAST = 4'd11;
	localparam logic [POS_W-1:0]  POS_MODE_MSB = 5'd26;
	localparam logic [POS_W-1:0]  POS_MODE_LSB = 5'd24;
	localparam logic [POS_W-1:0]  POS_DATA_MSB = 5'd15;
	localparam logic [POS_W-1:0]  POS_DATA_LSB = 5'd0;

	localparam logic [HALF_W-1:0] RST_UNIT   = 14'd444;
	localparam logic [HALF_W-1:0] RST_TRAIL  = 14'd889;
	localparam logic [DUR_W-1:0]  RST_LMARK  = 16'd2666;
	localparam logic [DUR_W-1:0]  RST_LSPACE = 16'd889;
	localparam logic [DUR_W-1:0]  RST_GAP    = 16'd45000;

	typedef enum logic [IDX_W-1:0] {
		CFG_UNIT   = 3'd0,
		CFG_TRAIL  = 3'd1,
		CFG_LMARK  = 3'd2,
		CFG_LSPACE = 3'd3,
		CFG_GAP    = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		LV_ZERO = 3'd0,
		LV_ONE  = 3'd1,
		LV_BIT  = 3'd2,
		LV_NBIT = 3'd3,
		LV_TOG  = 3'd4,
		LV_NTOG = 3'd5
	} lvl_src_t;

	typedef enum logic [2:0] {
		DS_UNIT   = 3'd0,
		DS_TRAIL  = 3'd1,
		DS_LMARK  = 3'd2,
		DS_LSPACE = 3'd3,
		DS_GAP    = 3'd4
	} dur_src_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_LOAD = 2'd1,
		CNT_DEC  = 2'd2
	} cnt_op_t;

	typedef struct packed {
		op_t               op;
		lvl_src_t          lvl;
		dur_src_t          dur;
		logic              merge;
		logic              last;
		cnt_op_t           cnt;
		logic [POS_W-1:0]  cnt_val;
		logic              jmp;
		logic [POS_W-1:0]  jmp_stop;
		logic [STEP_W-1:0] target;
		logic              fin;
	} ctrl_t;

	typedef struct packed {
		logic [HALF_W-1:0] unit_half;
		logic [HALF_W-1:0] trail_half;
		logic [DUR_W-1:0]  lmark;
		logic [DUR_W-1:0]  lspace;
		logic [DUR_W-1:0]  gap;
	} cfg_t;

	// one span request from the sequencer to the datapath
	typedef struct packed {
		logic             active;
		op_t              op;
		logic             lvl;
		logic [DUR_W-1:0] dur;
		logic             merge;
		logic             last;
	} req_t;

	typedef struct packed {
		logic              busy;
		logic [STEP_W-1:0] step;
		logic [POS_W-1:0]  pos;
	} seq_stat_t;

	function automatic ctrl_t mk(input op_t op, input lvl_src_t lvl, input dur_src_t dur,
		input logic merge, input logic last, input cnt_op_t cnt,
		input logic [POS_W-1:0] cnt_val, input logic jmp,
		input logic [POS_W-1:0] jmp_stop, input logic [STEP_W-1:0] target,
		input logic fin);
		ctrl_t c;
		c.op       = op;
		c.lvl      = lvl;
		c.dur      = dur;
		c.merge    = merge;
		c.last     = last;
		c.cnt      = cnt;
		c.cnt_val  = cnt_val;
		c.jmp      = jmp;
		c.jmp_stop = jmp_stop;
		c.target   = target;
		c.fin      = fin;
		return c;
	endfunction

	// control program: one span push (or flush) per step
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		unique case (step)
			4'd0:  c = mk(OP_PUSH, LV_ONE, DS_LMARK, 1'b0, 1'b0, CNT_LOAD, POS_MODE_MSB,
				1'b0, '0, '0, 1'b0);
			4'd1:  c = mk(OP_PUSH, LV_ZERO, DS_LSPACE, 1'b0, 1'b0, CNT_HOLD, '0,
				1'b0, '0, '0, 1'b0);
			4'd2:  c = mk(OP_PUSH, LV_ONE, DS_UNIT, 1'b1, 1'b0, CNT_HOLD, '0,
				1'b0, '0, '0, 1'b0);
			4'd3:  c = mk(OP_PUSH, LV_ZERO, DS_UNIT, 1'b1, 1'b0, CNT_HOLD, '0,
				1'b0, '0, '0, 1'b0);
			4'd4:  c = mk(OP_PUSH, LV_BIT, DS_UNIT, 1'b1, 1'b0, CNT_HOLD, '0,
				1'b0, '0, '0, 1'b0);
			4'd5:  c = mk(OP_PUSH, LV_NBIT, DS_UNIT, 1'b1, 1'b0, CNT_DEC, '0,
				1'b1, POS_MODE_LSB, 4'd4, 1'b0);
			4'd6:  c = mk(OP_PUSH, LV_TOG, DS_TRAIL, 1'b1, 1'b0, CNT_LOAD, POS_DATA_MSB,
				1'b0, '0, '0, 1'b0);
			4'd7:  c = mk(OP_PUSH, LV_NTOG, DS_TRAIL, 1'b1, 1'b0, CNT_HOLD, '0,
				1'b0, '0, '0, 1'b0);
			4'd8:  c = mk(OP_PUSH, LV_BIT, DS_UNIT, 1'b1, 1'b0, CNT_HOLD, '0,
				1'b0, '0, '0, 1'b0);
			4'd9:  c = mk(OP_PUSH, LV_NBIT, DS_UNIT, 1'b1, 1'b0, CNT_DEC, '0,
				1'b1, POS_DATA_LSB, 4'd8, 1'b0);
			4'd10: c = mk(OP_PUSH, LV_ZERO, DS_GAP, 1'b0, 1'b0, CNT_HOLD, '0,
				1'b0, '0, '0, 1'b0);
			default: c = mk(OP_FLUSH, LV_ZERO, DS_GAP, 1'b0, 1'b1, CNT_HOLD, '0,
				1'b0, '0, '0, 1'b1);
		endcase
		return c;
	endfunction

endpackage

FILE: src/rc6fe_seq.sv
// ----------------------------------------------------------------------------
// rc6fe_seq
// Step counter, program lookup and bit counter; builds span requests.
// ----------------------------------------------------------------------------
module rc6fe_seq import rc6fe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       code_word,
	input  cfg_t              cfg,
	input  logic              go,
	output req_t              req,
	output seq_stat_t         stat
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [POS_W-1:0]  pos_q;
	logic [CODE_W-1:0] code_q;
	ctrl_t             cw;
	logic              bit_v;
	logic              tog;
	logic              take_jmp;

	assign cw       = ucode(step_q);
	assign bit_v    = code_q[pos_q];
	assign tog      = |code_q[23:16];
	assign take_jmp = cw.jmp && (pos_q != cw.jmp_stop);

	always_comb begin
		req.active = busy_q;
		req.op     = cw.op;
		req.merge  = cw.merge;
		req.last   = cw.last;
		unique case (cw.lvl)
			LV_ZERO: req.lvl = 1'b0;
			LV_ONE:  req.lvl = 1'b1;
			LV_BIT:  req.lvl = bit_v;
			LV_NBIT: req.lvl = ~bit_v;
			LV_TOG:  req.lvl = tog;
			LV_NTOG: req.lvl = ~tog;
			default: req.lvl = 1'b0;
		endcase
		unique case (cw.dur)
			DS_UNIT:   req.dur = {2'b00, cfg.unit_half};
			DS_TRAIL:  req.dur = {2'b00, cfg.trail_half};
			DS_LMARK:  req.dur = cfg.lmark;
			DS_LSPACE: req.dur = cfg.lspace;
			DS_GAP:    req.dur = cfg.gap;
			default:   req.dur = cfg.gap;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			pos_q  <= '0;
			code_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			code_q <= code_word[CODE_W-1:0];
		end else if (busy_q && go) begin
			// the counter stops on the last bit of a loop instead of wrapping
			unique case (cw.cnt)
				CNT_LOAD: pos_q <= cw.cnt_val;
				CNT_DEC:  pos_q <= (pos_q == cw.jmp_stop) ? pos_q : pos_q - 1'b1;
				default:  pos_q <= pos_q;
			endcase
			if (cw.fin) begin
				busy_q <= 1'b0;
				step_q <= '0;
				pos_q  <= '0;
			end else if (take_jmp) begin
				step_q <= cw.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.step = step_q;
	assign stat.pos  = pos_q;

endmodule

FILE: src/rc6fe_datapath.sv
// ----------------------------------------------------------------------------
// rc6fe_datapath
// Merge accumulator for adjacent equal halves and the output register.
// ----------------------------------------------------------------------------
module rc6fe_datapath import rc6fe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	output logic             go,
	output logic             acc_valid,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             level,
	output logic [DUR_W-1:0] duration_us,
	output logic             last
);

	logic             acc_valid_q;
	logic             acc_lvl_q;
	logic [DUR_W-1:0] acc_dur_q;
	logic             out_valid_q;
	logic             out_lvl_q;
	logic [DUR_W-1:0] out_dur_q;
	logic             out_last_q;
	logic             merge_hit;
	logic             need_emit;
	logic             slot_free;

	assign merge_hit = (req.op == OP_PUSH) && req.merge && acc_valid_q
		&& (acc_lvl_q == req.lvl);
	assign need_emit = acc_valid_q && !merge_hit;
	assign slot_free = !out_valid_q || out_ready;
	assign go        = req.active && (!need_emit || slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go && need_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				acc_valid_q <= (req.op == OP_PUSH);
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (go && need_emit) begin
			out_lvl_q  <= acc_lvl_q;
			out_dur_q  <= acc_dur_q;
			out_last_q <= req.last;
		end
		if (go && (req.op == OP_PUSH)) begin
			acc_lvl_q <= req.lvl;
			acc_dur_q <= merge_hit ? (acc_dur_q + req.dur) : req.dur;
		end
	end

	assign acc_valid   = acc_valid_q;
	assign out_valid   = out_valid_q;
	assign level       = out_lvl_q;
	assign duration_us = out_dur_q;
	assign last        = out_last_q;

endmodule

FILE: src/rc6_frame_pulse_encoder.sv
// ----------------------------------------------------------------------------
// rc6_frame_pulse_encoder
// RC6 mode-0 frame encoder: one code word in, mark/space durations out.
// ----------------------------------------------------------------------------
// The first duration, the leader mark, is emitted when step 1 pushes the space.
// A new code word is accepted only while the sequencer is idle; each step of
// the control program pushes one span, and the last step flushes it out.
// Output backpressure stalls the step counter when a span must leave and the output register is still full.
// Reset: config registers return to their RST_ defaults, sequencer idle; the output payload is not reset.
module rc6_frame_pulse_encoder import rc6fe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0] cfg_data,
	input  logic [31:0]      code_word,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             level,
	output logic [DUR_W-1:0] duration_us,
	output logic             last,
	output logic             out_valid,
	input  logic             out_ready
);

	cfg_t      cfg_q;
	req_t      req;
	seq_stat_t stat;
	logic      go;
	logic      acc_valid;
	logic      start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_half  <= RST_UNIT;
			cfg_q.trail_half <= RST_TRAIL;
			cfg_q.lmark      <= RST_LMARK;
			cfg_q.lspace     <= RST_LSPACE;
			cfg_q.gap        <= RST_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNIT:   cfg_q.unit_half  <= cfg_data[HALF_W-1:0];
				CFG_TRAIL:  cfg_q.trail_half <= cfg_data[HALF_W-1:0];
				CFG_LMARK:  cfg_q.lmark      <= cfg_data;
				CFG_LSPACE: cfg_q.lspace     <= cfg_data;
				CFG_GAP:    cfg_q.gap        <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_ready = !stat.busy;
	assign start    = in_valid && in_ready;

	rc6fe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.code_word (code_word),
		.cfg       (cfg_q),
		.go        (go),
		.req       (req),
		.stat      (stat)
	);

	rc6fe_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.go          (go),
		.acc_valid   (acc_valid),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.level       (level),
		.duration_us (duration_us),
		.last        (last)
	);

	// idle sequencer never leaves a half-built span behind
	a_idle_acc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !acc_valid)
		else $error("accumulator holds a span while idle");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> (stat.step <= STEP_LAST))
		else $error("step counter ran past the program");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> (stat.pos <= POS_MODE_MSB))
		else $error("bit counter out of range");

	a_start_step: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (stat.busy && (stat.step == '0)))
		else $error("transfer did not start the program");

endmodule
